FILE: rtl/core/bsd_pkg.sv
`timescale 1ns / 1ps

package bsd_pkg;

   // field widths fixed by the interface
   localparam int COORD_W     = 10;
   localparam int INNER_W     = 10;
   localparam int RADIUS_W    = 4;
   localparam int CSR_DATA_W  = 10;
   localparam int CSR_INDEX_W = 2;

   // register map
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_INNER_WIDTH  = 2'd0,
      CSR_INNER_HEIGHT = 2'd1,
      CSR_RADIUS       = 2'd2
   } csr_reg_type;

   // control handed to every window cell
   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

endpackage

FILE: rtl/core/bsd_ram.sv
`timescale 1ns / 1ps

module bsd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/bsd_cell.sv
`timescale 1ns / 1ps

module bsd_cell #(
   parameter int INDEX  = 0,
   parameter int POS_W  = 11,
   parameter int DIAM_W = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bsd_pkg::cell_ctrl_type ctrl,
   input  logic                  shift_in,
   input  logic [POS_W-1:0]      span,
   input  logic [POS_W-1:0]      line_w,
   input  logic [DIAM_W-1:0]     diam,
   input  logic                  or_in,
   output logic                  q,
   output logic                  or_out
);

   import bsd_pkg::*;

   logic bit_ff;
   logic bit_in;
   logic in_span;

   // tap lies inside the window and inside the current row
   assign in_span = (POS_W'(INDEX) <= span)
                 && ((span - POS_W'(INDEX)) < line_w)
                 && (DIAM_W'(INDEX) <= diam);

   // contribution uses the value this cell takes on the shift
   assign or_out = or_in | (shift_in & in_span);

   always_comb begin
      bit_in = bit_ff;
      if (ctrl.clear) begin
         bit_in = 1'b0;
      end else if (ctrl.shift) begin
         bit_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= 1'b0;
      end else begin
         bit_ff <= bit_in;
      end
   end

   assign q = bit_ff;

endmodule

FILE: rtl/core/binary_square_dilation_top.sv
`timescale 1ns / 1ps

// binary square dilation, (2r+1) x (2r+1) window over a one-bit mask
// req_ channel: one transfer per beat of the padded frame in raster order
//   (action 0 = pixel, action 1 = flush beat read as zero), then flush beats
// rsp_ channel: one dilated pixel with its padded-frame column and row, and
//   frame_end on the last pixel; beats inside the lookahead of r rows and
//   r columns give no transfer
// csr_ channel: register index and data, always ready; any write, even to an
//   unknown index, restarts the frame; write only while the block is idle
// a result passes the history stage and the output register on its way to rsp_
// throughput: one beat per cycle unless the receiver stalls, set by the window
//   cell chain and the column history ram (one read and one write per cycle)
// the horizontal window is a chain of 2*MAX_RADIUS+1 cells shifting on each
//   transfer; column histories live in a MAX_LINE-deep ram, read as zero on
//   the first row of a frame, so no clearing pass is needed after reset
// reset (synchronous) restores the registers and starts a new frame
// a stalled receiver holds the output register; one more beat is taken into
//   the history stage, after which req_ready drops until rsp_ready returns

module binary_square_dilation_top #(
   parameter int MAX_LINE   = 1024,
   parameter int MAX_RADIUS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_action,
   input  logic                                 req_pixel,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_out_pixel,
   output logic [bsd_pkg::COORD_W-1:0]          rsp_out_x,
   output logic [bsd_pkg::COORD_W-1:0]          rsp_out_y,
   output logic                                 rsp_frame_end,
   // register write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bsd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [bsd_pkg::CSR_DATA_W-1:0]       csr_data
);

   import bsd_pkg::*;

   localparam int CW        = $clog2(MAX_LINE);
   localparam int PW        = $clog2(MAX_LINE + 2 * MAX_RADIUS + 1);
   localparam int RADW      = $clog2(MAX_RADIUS + 1);
   localparam int DW        = $clog2(2 * MAX_RADIUS + 1);
   localparam int HW        = 2 * MAX_RADIUS;
   localparam int WL        = 2 * MAX_RADIUS + 1;
   localparam int INNER_TOP = MAX_LINE - 2 * MAX_RADIUS;

   function automatic logic [PW-1:0] clamp_inner(input logic [INNER_W-1:0] v);
      if (v == '0) begin
         return PW'(1);
      end
      if (int'(v) > INNER_TOP) begin
         return PW'(INNER_TOP);
      end
      return PW'(v);
   endfunction

   // configuration registers
   logic [INNER_W-1:0]  inner_width_ff;
   logic [INNER_W-1:0]  inner_height_ff;
   logic [RADIUS_W-1:0] radius_ff;

   // raster position of the next beat
   logic [CW-1:0] col_ff, col_in;
   logic [PW-1:0] row_ff, row_in;

   // history stage
   logic          s1_valid_ff;
   logic          s1_center_ff;
   logic          s1_emit_ff;
   logic          s1_first_ff;
   logic          s1_fend_ff;
   logic          s1_hbit_ff;
   logic          s1_byp_ff;
   logic [HW-1:0] s1_byp_data_ff;
   logic [CW-1:0] s1_c_ff;
   logic [PW-1:0] s1_yo_ff;

   // output register
   logic                rsp_valid_ff;
   logic                rsp_pixel_ff;
   logic [COORD_W-1:0]  rsp_x_ff;
   logic [COORD_W-1:0]  rsp_y_ff;
   logic                rsp_fend_ff;

   logic          csr_transfer;
   logic          req_transfer;
   logic          out_free;
   logic          s1_go;

   logic [RADW-1:0] r_eff;
   logic [PW-1:0]   r_p;
   logic [DW-1:0]   two_r;
   logic [PW-1:0]   frame_w;
   logic [PW-1:0]   frame_h;
   logic [HW-1:0]   hist_mask;

   logic          beat_bit;
   logic [PW-1:0] col_p;
   logic [PW-1:0] col_next;
   logic          have_center;
   logic [PW-1:0] c0;
   logic [PW-1:0] yc0;
   logic [PW-1:0] yo0;
   logic          emit0;
   logic          fend0;
   logic [PW-1:0] span0;
   logic          frame_clear;

   logic [WL-1:0] win_q;
   logic [WL:0]   or_chain;
   logic          hbit0;
   cell_ctrl_type cell_ctrl;

   logic          ram_we;
   logic [HW-1:0] ram_rd_data;
   logic [HW-1:0] hist_raw;
   logic [HW-1:0] hist_cur;
   logic [HW-1:0] hist_next;
   logic          vbit;
   logic          byp0;

   assign csr_ready    = 1'b1;
   assign csr_transfer = csr_valid & csr_ready;

   // configuration decode
   always_ff @(posedge clock) begin
      if (reset) begin
         inner_width_ff  <= INNER_W'(1);
         inner_height_ff <= INNER_W'(1);
         radius_ff       <= '0;
      end else if (csr_transfer) begin
         unique case (csr_index)
            CSR_INNER_WIDTH:  inner_width_ff  <= csr_data[INNER_W-1:0];
            CSR_INNER_HEIGHT: inner_height_ff <= csr_data[INNER_W-1:0];
            CSR_RADIUS:       radius_ff       <= csr_data[RADIUS_W-1:0];
            default:          ;
         endcase
      end
   end

   // effective frame geometry
   always_comb begin
      if (int'(radius_ff) > MAX_RADIUS) begin
         r_eff = RADW'(MAX_RADIUS);
      end else begin
         r_eff = RADW'(radius_ff);
      end
   end

   assign r_p       = PW'(r_eff);
   assign two_r     = DW'({r_eff, 1'b0});
   assign frame_w   = clamp_inner(inner_width_ff) + PW'(two_r);
   assign frame_h   = clamp_inner(inner_height_ff) + PW'(two_r);
   assign hist_mask = ~({HW{1'b1}} << two_r);

   // handshake: the history stage moves unless its result is blocked
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign s1_go        = s1_valid_ff && (!s1_emit_ff || out_free);
   assign req_ready    = !s1_valid_ff || s1_go;
   assign req_transfer = req_valid && req_ready;

   // beat intake: zero for flush beats and beats past the frame
   assign beat_bit = !req_action && (row_ff < frame_h) && req_pixel;

   // window centre lags the newest beat by r positions in raster order
   assign col_p = PW'(col_ff);
   always_comb begin
      have_center = 1'b1;
      c0          = '0;
      yc0         = '0;
      if (col_p >= r_p) begin
         c0  = col_p - r_p;
         yc0 = row_ff;
      end else if (row_ff != '0) begin
         c0  = col_p + frame_w - r_p;
         yc0 = row_ff - PW'(1);
      end else begin
         have_center = 1'b0;
      end
   end

   assign yo0   = yc0 - r_p;
   assign emit0 = have_center && (yc0 >= r_p) && (yo0 < frame_h);
   assign fend0 = emit0 && (c0 == frame_w - PW'(1)) && (yo0 == frame_h - PW'(1));
   assign span0 = c0 + r_p;

   assign frame_clear = csr_transfer || (req_transfer && fend0);

   // raster counters
   assign col_next = col_p + PW'(1);
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (frame_clear) begin
         col_in = '0;
         row_in = '0;
      end else if (req_transfer) begin
         if (col_next >= frame_w) begin
            col_in = '0;
            row_in = row_ff + PW'(1);
         end else begin
            col_in = CW'(col_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // horizontal window: chain of cells, each ORing its tap when in range
   assign cell_ctrl.shift = req_transfer;
   assign cell_ctrl.clear = frame_clear;
   assign or_chain[0]     = 1'b0;

   for (genvar j = 0; j < WL; j++) begin : g_cell
      logic shift_src;
      if (j == 0) begin : g_head
         assign shift_src = beat_bit;
      end else begin : g_tail
         assign shift_src = win_q[j-1];
      end
      bsd_cell #(
         .INDEX  (j),
         .POS_W  (PW),
         .DIAM_W (DW)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (cell_ctrl),
         .shift_in (shift_src),
         .span     (span0),
         .line_w   (frame_w),
         .diam     (two_r),
         .or_in    (or_chain[j]),
         .q        (win_q[j]),
         .or_out   (or_chain[j+1])
      );
   end

   assign hbit0 = or_chain[WL];

   // column history store
   assign ram_we = s1_go && s1_center_ff;
   // a write to the address being read in the same cycle is forwarded
   assign byp0   = ram_we && (s1_c_ff == CW'(c0));

   bsd_ram #(
      .WIDTH (HW),
      .DEPTH (MAX_LINE)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s1_c_ff),
      .wr_data (hist_next),
      .rd_en   (req_transfer),
      .rd_addr (CW'(c0)),
      .rd_data (ram_rd_data)
   );

   // history stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_transfer) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_transfer) begin
         s1_center_ff   <= have_center;
         s1_emit_ff     <= emit0;
         s1_first_ff    <= (yc0 == '0);
         s1_fend_ff     <= fend0;
         s1_hbit_ff     <= hbit0;
         s1_byp_ff      <= byp0;
         s1_byp_data_ff <= hist_next;
         s1_c_ff        <= CW'(c0);
         s1_yo_ff       <= yo0;
      end
   end

   // vertical OR over the last 2r horizontal results of the column
   assign hist_raw  = s1_byp_ff ? s1_byp_data_ff : ram_rd_data;
   assign hist_cur  = s1_first_ff ? '0 : hist_raw;
   assign vbit      = s1_hbit_ff || ((hist_cur & hist_mask) != '0);
   assign hist_next = {hist_cur[HW-2:0], s1_hbit_ff};

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go && s1_emit_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_emit_ff) begin
         rsp_pixel_ff <= vbit;
         rsp_x_ff     <= COORD_W'(s1_c_ff);
         rsp_y_ff     <= COORD_W'(s1_yo_ff);
         rsp_fend_ff  <= s1_fend_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_pixel = rsp_pixel_ff;
   assign rsp_out_x     = rsp_x_ff;
   assign rsp_out_y     = rsp_y_ff;
   assign rsp_frame_end = rsp_fend_ff;

endmodule

FILE: tb/binary_square_dilation_top_test.sv
`timescale 1ns / 1ps

module binary_square_dilation_top_test;

   import bsd_pkg::*;

   localparam int MAX_LINE     = 1024;
   localparam int MAX_RADIUS   = 8;
   localparam int HIST_W       = 2 * MAX_RADIUS;
   localparam int WIN_W        = 2 * MAX_RADIUS + 1;
   localparam int INNER_TOP    = MAX_LINE - 2 * MAX_RADIUS;
   localparam int ITEMS_TARGET = 1850;
   // beats left over before a large-radius phase is still worth starting
   localparam int BIG_BUDGET   = 600;
   // idle margin once every owed result has come back through the pipe
   localparam int SETTLE       = 8;
   localparam int DIR_ROWS     = 27;

   // index outside the register map, still restarts the frame
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   typedef enum logic {
      BEAT_PIXEL = 1'b0,
      BEAT_FLUSH = 1'b1
   } beat_kind_type;

   typedef enum logic [1:0] {
      ROW_BEAT,
      ROW_CSR
   } row_kind_type;

   // how a directed row is checked
   typedef enum logic [1:0] {
      CHK_MODEL,
      CHK_NONE,
      CHK_FIXED
   } row_check_type;

   typedef struct packed {
      logic                 pixel;
      logic [COORD_W-1:0]   x;
      logic [COORD_W-1:0]   y;
      logic                 frame_end;
   } dilated_type;

   typedef struct packed {
      row_kind_type            kind;
      logic [CSR_INDEX_W-1:0]  index;
      logic [CSR_DATA_W-1:0]   data;
      beat_kind_type           act;
      logic                    pix;
      row_check_type           chk;
      dilated_type             want;
   } dir_row_type;

   localparam dilated_type NO_PEL = '0;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_action = 1'b0;
   logic                    req_pixel = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic                    rsp_out_pixel;
   logic [COORD_W-1:0]      rsp_out_x;
   logic [COORD_W-1:0]      rsp_out_y;
   logic                    rsp_frame_end;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_data = '0;

   // dilated pixels still owed by the block, oldest first
   dilated_type expected_pixels[$];

   // shadow of the block: registers and frame state
   logic [INNER_W-1:0]   cfg_width;
   logic [INNER_W-1:0]   cfg_height;
   logic [RADIUS_W-1:0]  cfg_radius;
   logic [HIST_W-1:0]    col_hist [MAX_LINE];
   logic [WIN_W-1:0]     recent_bits;
   int                   next_col;
   int                   next_row;

   // run bookkeeping
   int  failures = 0;
   int  beats_sent = 0;
   int  csr_writes = 0;
   int  results_checked = 0;
   int  frames_closed = 0;
   bit  no_idle = 1'b0;
   int  rsp_wait = 0;

   dir_row_type dir_rows [DIR_ROWS];

   binary_square_dilation_top #(
      .MAX_LINE   (MAX_LINE),
      .MAX_RADIUS (MAX_RADIUS)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_pixel     (req_pixel),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_pixel (rsp_out_pixel),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_frame_end (rsp_frame_end),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   // 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // shadow of the dilation
   // ---------------------------------------------------------------

   function automatic int inner_clamp(input logic [INNER_W-1:0] v);
      if (v == 0) return 1;
      if (int'(v) > INNER_TOP) return INNER_TOP;
      return int'(v);
   endfunction

   // oversized radius saturates at the build limit
   function automatic int frame_radius();
      return (int'(cfg_radius) > MAX_RADIUS) ? MAX_RADIUS : int'(cfg_radius);
   endfunction

   function automatic int frame_width();
      return inner_clamp(cfg_width) + 2 * frame_radius();
   endfunction

   function automatic int frame_height();
      return inner_clamp(cfg_height) + 2 * frame_radius();
   endfunction

   function automatic void clear_frame();
      foreach (col_hist[i]) col_hist[i] = '0;
      recent_bits = '0;
      next_col = 0;
      next_row = 0;
   endfunction

   // any write, known index or not, restarts the frame
   function automatic void apply_csr(input logic [CSR_INDEX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_INNER_WIDTH:  cfg_width = data[INNER_W-1:0];
         CSR_INNER_HEIGHT: cfg_height = data[INNER_W-1:0];
         CSR_RADIUS:       cfg_radius = data[RADIUS_W-1:0];
         default: ;
      endcase
      clear_frame();
   endfunction

   // one beat through the window; returns 1 when a dilated pixel comes out
   function automatic bit dilate_beat(input beat_kind_type act, input logic pix,
                                      output dilated_type res);
      int r, w, h, c, yc, yo;
      logic in_bit, hbit, vbit, centred;
      logic [HIST_W-1:0] hist, mask;
      r = frame_radius();
      w = frame_width();
      h = frame_height();
      res = '0;
      // flush beats and anything below the last row count as zero
      in_bit = (act == BEAT_PIXEL && next_row < h) ? pix : 1'b0;
      recent_bits = {recent_bits[WIN_W-2:0], in_bit};
      // window centre sits r beats back in raster order
      centred = 1'b1;
      c = 0;
      yc = 0;
      if (next_col >= r) begin
         c = next_col - r;
         yc = next_row;
      end else if (next_row > 0) begin
         c = next_col + w - r;
         yc = next_row - 1;
      end else begin
         centred = 1'b0;
      end
      next_col++;
      if (next_col >= w) begin
         next_col = 0;
         next_row++;
      end
      if (!centred || c >= w || c >= MAX_LINE) return 1'b0;
      hbit = 1'b0;
      for (int d = -r; d <= r; d++) begin
         if (c + d >= 0 && c + d < w && recent_bits[r - d]) hbit = 1'b1;
      end
      hist = col_hist[c];
      mask = HIST_W'((1 << (2 * r)) - 1);
      vbit = hbit | (|(hist & mask));
      col_hist[c] = {hist[HIST_W-2:0], hbit};
      // still inside the vertical lookahead
      if (yc < r) return 1'b0;
      yo = yc - r;
      if (yo >= h) return 1'b0;
      res.pixel = vbit;
      res.x = c[COORD_W-1:0];
      res.y = yo[COORD_W-1:0];
      res.frame_end = (c == w - 1 && yo == h - 1);
      if (res.frame_end) clear_frame();
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------
   // directed table helpers
   // ---------------------------------------------------------------

   function automatic dilated_type pel(input logic p, input int x, input int y,
                                       input logic e);
      dilated_type v;
      v.pixel = p;
      v.x = x[COORD_W-1:0];
      v.y = y[COORD_W-1:0];
      v.frame_end = e;
      return v;
   endfunction

   function automatic dir_row_type beat_row(input beat_kind_type act, input logic pix,
                                            input row_check_type chk,
                                            input dilated_type want);
      dir_row_type row;
      row = '0;
      row.kind = ROW_BEAT;
      row.act = act;
      row.pix = pix;
      row.chk = chk;
      row.want = want;
      return row;
   endfunction

   function automatic dir_row_type csr_row(input logic [CSR_INDEX_W-1:0] idx,
                                           input logic [CSR_DATA_W-1:0] data);
      dir_row_type row;
      row = '0;
      row.kind = ROW_CSR;
      row.index = idx;
      row.data = data;
      row.chk = CHK_NONE;
      return row;
   endfunction

   // ---------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------

   // one beat, after a random gap; the shadow is stepped on the transfer
   task automatic send_beat(input beat_kind_type act, input logic pix,
                            input row_check_type chk, input dilated_type want);
      int gap;
      dilated_type res;
      bit got;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_pixel <= pix;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      got = dilate_beat(act, pix, res);
      case (chk)
         CHK_MODEL: if (got) expected_pixels.push_back(res);
         CHK_FIXED: expected_pixels.push_back(want);
         default: ;
      endcase
      beats_sent++;
   endtask

   // hold off until every owed pixel is back and the pipe has gone quiet
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // leaves csr_valid high so back-to-back writes need no dip
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_csr(idx, data);
      csr_writes++;
   endtask

   // one padded frame in raster order, then the flush beats
   task automatic send_frame(input bit broken);
      int w, h, r, total, beats, density, row;
      beat_kind_type act;
      logic pix;
      w = frame_width();
      h = frame_height();
      r = frame_radius();
      total = h * w + r * w + r;
      // a cut-short frame is abandoned at the next register write
      beats = broken ? $urandom_range(1, total) : total;
      density = $urandom_range(0, 100);
      for (int k = 0; k < beats; k++) begin
         row = k / w;
         if (row < h) begin
            act = ($urandom_range(0, 19) == 0) ? BEAT_FLUSH : BEAT_PIXEL;
            pix = ($urandom_range(1, 100) <= density);
         end else begin
            // past the last row both fields are don't-care
            act = beat_kind_type'($urandom_range(0, 1));
            pix = $urandom_range(0, 1);
         end
         send_beat(act, pix, CHK_MODEL, NO_PEL);
         if ($urandom_range(0, 499) == 0) drain();
      end
   endtask

   // new register setting, then a few frames under it
   task automatic run_phase(input logic [CSR_DATA_W-1:0] width_data,
                            input logic [CSR_DATA_W-1:0] height_data,
                            input logic [CSR_DATA_W-1:0] radius_data,
                            input int frames, input bit steady, input bit broken_last);
      drain();
      no_idle = steady;
      if ($urandom_range(0, 3) == 0) write_reg(CSR_SPARE, CSR_DATA_W'($urandom));
      write_reg(CSR_INNER_WIDTH, width_data);
      write_reg(CSR_INNER_HEIGHT, height_data);
      write_reg(CSR_RADIUS, radius_data);
      csr_valid <= 1'b0;
      for (int f = 0; f < frames; f++) send_frame(broken_last && f == frames - 1);
   endtask

   // ---------------------------------------------------------------
   // result side: random stalls and the field compare
   // ---------------------------------------------------------------

   always @(posedge clock) begin
      dilated_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               $error("unexpected result transfer: x=%0d y=%0d pixel=%0d",
                      rsp_out_x, rsp_out_y, rsp_out_pixel);
               failures++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_out_pixel !== want.pixel) begin
                  $error("out_pixel mismatch: expected %0d, got %0d",
                         want.pixel, rsp_out_pixel);
                  failures++;
               end
               if (rsp_out_x !== want.x) begin
                  $error("out_x mismatch: expected %0d, got %0d", want.x, rsp_out_x);
                  failures++;
               end
               if (rsp_out_y !== want.y) begin
                  $error("out_y mismatch: expected %0d, got %0d", want.y, rsp_out_y);
                  failures++;
               end
               if (rsp_frame_end !== want.frame_end) begin
                  $error("frame_end mismatch: expected %0d, got %0d",
                         want.frame_end, rsp_frame_end);
                  failures++;
               end
            end
            results_checked++;
            if (rsp_frame_end === 1'b1) frames_closed++;
            rsp_wait = no_idle ? 0 : $urandom_range(0, 5);
            rsp_ready <= (rsp_wait == 0);
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_ready <= (rsp_wait == 0);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------

   initial begin
      int rr, ww, hh;
      bit big;
      logic [CSR_DATA_W-RADIUS_W-1:0] pad;
      logic [RADIUS_W-1:0] r4;

      // power-on register values
      cfg_width = INNER_W'(1);
      cfg_height = INNER_W'(1);
      cfg_radius = '0;
      clear_frame();

      dir_rows = '{
         // after reset the frame is a single pixel, so every transfer
         // closes a frame; flush action reads as zero
         beat_row(BEAT_PIXEL, 1'b1, CHK_FIXED, pel(1'b1, 0, 0, 1'b1)),
         beat_row(BEAT_PIXEL, 1'b0, CHK_FIXED, pel(1'b0, 0, 0, 1'b1)),
         beat_row(BEAT_FLUSH, 1'b1, CHK_FIXED, pel(1'b0, 0, 0, 1'b1)),
         beat_row(BEAT_FLUSH, 1'b0, CHK_FIXED, pel(1'b0, 0, 0, 1'b1)),
         // radius 1 around a 1x1 mask: 3x3 frame, lookahead of four beats
         csr_row(CSR_RADIUS, 10'd1),
         beat_row(BEAT_PIXEL, 1'b0, CHK_NONE, NO_PEL),
         beat_row(BEAT_PIXEL, 1'b0, CHK_NONE, NO_PEL),
         beat_row(BEAT_PIXEL, 1'b0, CHK_NONE, NO_PEL),
         beat_row(BEAT_PIXEL, 1'b0, CHK_NONE, NO_PEL),
         // lone centre pixel grows to fill the whole frame
         beat_row(BEAT_PIXEL, 1'b1, CHK_FIXED, pel(1'b1, 0, 0, 1'b0)),
         beat_row(BEAT_PIXEL, 1'b0, CHK_FIXED, pel(1'b1, 1, 0, 1'b0)),
         beat_row(BEAT_PIXEL, 1'b0, CHK_FIXED, pel(1'b1, 2, 0, 1'b0)),
         beat_row(BEAT_PIXEL, 1'b0, CHK_FIXED, pel(1'b1, 0, 1, 1'b0)),
         beat_row(BEAT_PIXEL, 1'b0, CHK_FIXED, pel(1'b1, 1, 1, 1'b0)),
         // trailing beats below the frame, set pixels ignored
         beat_row(BEAT_FLUSH, 1'b1, CHK_FIXED, pel(1'b1, 2, 1, 1'b0)),
         beat_row(BEAT_PIXEL, 1'b1, CHK_FIXED, pel(1'b1, 0, 2, 1'b0)),
         beat_row(BEAT_FLUSH, 1'b0, CHK_FIXED, pel(1'b1, 1, 2, 1'b0)),
         beat_row(BEAT_PIXEL, 1'b1, CHK_FIXED, pel(1'b1, 2, 2, 1'b1)),
         // unmapped index, zero width, radius beyond the build limit
         csr_row(CSR_SPARE, 10'h3ff),
         csr_row(CSR_INNER_WIDTH, 10'd0),
         csr_row(CSR_RADIUS, 10'h3ff),
         beat_row(BEAT_PIXEL, 1'b1, CHK_MODEL, NO_PEL),
         beat_row(BEAT_PIXEL, 1'b1, CHK_MODEL, NO_PEL),
         beat_row(BEAT_FLUSH, 1'b1, CHK_MODEL, NO_PEL),
         beat_row(BEAT_PIXEL, 1'b0, CHK_MODEL, NO_PEL),
         beat_row(BEAT_PIXEL, 1'b1, CHK_MODEL, NO_PEL),
         beat_row(BEAT_PIXEL, 1'b1, CHK_MODEL, NO_PEL)
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed rows; register writes only once the block has gone idle
      for (int i = 0; i < DIR_ROWS; i++) begin
         if (dir_rows[i].kind == ROW_CSR) begin
            if (i == 0 || dir_rows[i-1].kind != ROW_CSR) drain();
            write_reg(dir_rows[i].index, dir_rows[i].data);
            if (i == DIR_ROWS - 1 || dir_rows[i+1].kind != ROW_CSR) csr_valid <= 1'b0;
         end else begin
            send_beat(dir_rows[i].act, dir_rows[i].pix, dir_rows[i].chk, dir_rows[i].want);
         end
      end

      // size extremes: widest line, then both sizes at zero with the
      // largest radius code
      run_phase(10'd1023, 10'd1, 10'd0, 1, 1'b1, 1'b0);
      run_phase(10'd0, 10'd0, 10'h3ff, 1, 1'b0, 1'b0);

      // random settings, mostly small so frames stay short; a large radius
      // only while enough of the beat budget is left for its frame
      while (beats_sent < ITEMS_TARGET) begin
         big = (ITEMS_TARGET - beats_sent > BIG_BUDGET) && ($urandom_range(0, 4) == 0);
         rr = big ? $urandom_range(4, 15) : $urandom_range(0, 3);
         ww = $urandom_range(0, big ? 4 : 12);
         hh = $urandom_range(0, big ? 3 : 8);
         pad = (CSR_DATA_W-RADIUS_W)'($urandom);
         r4 = rr[RADIUS_W-1:0];
         run_phase(CSR_DATA_W'(ww), CSR_DATA_W'(hh), {pad, r4},
                   big ? 1 : $urandom_range(1, 2),
                   ($urandom_range(0, 6) == 0), ($urandom_range(0, 7) == 0));
      end

      drain();

      $display("covered %0d beats under %0d register writes, radius 0 to 15 and sizes 0 to 1023",
               beats_sent, csr_writes);
      $display("checked %0d dilated pixels across %0d closed frames",
               results_checked, frames_closed);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // watchdog
   initial begin
      #1000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
